// File: rtl/mpq_pkg.sv
`timescale 1ns / 1ps

package mpq_pkg;

	// Default store depth
	localparam int CAPACITY = 4;

	// Depth of the command queue between front and back
	localparam int FIFO_DEPTH = 2;

	// Action codes on the request
	localparam logic ACT_INSERT = 1'b0;
	localparam logic ACT_DELETE = 1'b1;

	// Result status codes
	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	typedef enum logic [0:0] {
		OP_INSERT = 1'b0,
		OP_DELETE = 1'b1
	} op_t;

	typedef struct packed {
		logic               action;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] removed_value;
		logic [2:0]         occupancy;
	} rsp_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] value;
	} cmd_t;

endpackage

// File: rtl/mpq_front.sv
`timescale 1ns / 1ps

module mpq_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  mpq_pkg::req_t request,
	output logic          busy,
	output logic          push,
	output mpq_pkg::cmd_t push_cmd,
	input  logic          push_ready
);

	logic          vld_s1;
	mpq_pkg::cmd_t cmd_s1;
	mpq_pkg::cmd_t cmd_dec;

	// Classify the request into a queue command
	always_comb begin
		cmd_dec.value = request.value;
		if (request.action == mpq_pkg::ACT_DELETE) begin
			cmd_dec.op = mpq_pkg::OP_DELETE;
		end else begin
			cmd_dec.op = mpq_pkg::OP_INSERT;
		end
	end

	// Stall only when the stage holds a command the queue cannot take
	assign busy     = vld_s1 && !push_ready;
	assign push     = vld_s1;
	assign push_cmd = cmd_s1;

	// Hold the accepted command until it moves into the queue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (start && !busy) begin
			vld_s1 <= 1'b1;
		end else if (vld_s1 && push_ready) begin
			vld_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			cmd_s1 <= cmd_dec;
		end
	end

endmodule

// File: rtl/mpq_fifo.sv
`timescale 1ns / 1ps

module mpq_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mpq_pkg::cmd_t push_cmd,
	output logic          push_ready,
	input  logic          pop,
	output mpq_pkg::cmd_t pop_cmd,
	output logic          pop_valid
);

	localparam int DEPTH = mpq_pkg::FIFO_DEPTH;
	localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int NW    = $clog2(DEPTH + 1);

	mpq_pkg::cmd_t slot_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] fill_q;
	logic          do_push;
	logic          do_pop;

	assign push_ready = (fill_q != NW'(DEPTH));
	assign pop_valid  = (fill_q != '0);
	assign pop_cmd    = slot_q[rd_ptr_q];
	assign do_push    = push && push_ready;
	assign do_pop     = pop && pop_valid;

	// Advance pointers and fill level on each transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + NW'(1);
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - NW'(1);
			end
		end
	end

	// Store the incoming command
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// File: rtl/mpq_back.sv
`timescale 1ns / 1ps

module mpq_back #(
	parameter int CAPACITY = mpq_pkg::CAPACITY
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cmd_valid,
	input  mpq_pkg::cmd_t cmd,
	output logic          cmd_pop,
	output logic          result_valid,
	output mpq_pkg::rsp_t result
);

	localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);

	typedef enum logic [3:0] {
		S_IDLE     = 4'b0001,
		S_SCAN     = 4'b0010,
		S_SHIFT_RD = 4'b0100,
		S_SHIFT_WR = 4'b1000
	} state_t;

	state_t             state_q;
	logic [31:0]        mem [CAPACITY];
	logic signed [31:0] rd_data_q;
	logic [AW-1:0]      rd_addr;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [31:0]        wr_data;

	logic [CW-1:0]      count_q;
	logic [CW-1:0]      issue_q;
	logic               pend_q;
	logic [CW-1:0]      pend_idx_q;
	logic [CW-1:0]      best_q;
	logic signed [31:0] min_q;
	logic [CW-1:0]      k_q;
	logic [CW-1:0]      k_inc;
	logic               take;
	logic               scan_last;
	logic               is_full;
	mpq_pkg::rsp_t      res_q;
	logic               res_vld_q;

	assign k_inc     = k_q + CW'(1);
	assign take      = (pend_idx_q == '0) || (rd_data_q < min_q);
	assign scan_last = pend_q && (pend_idx_q == count_q - CW'(1));
	assign is_full   = (count_q >= CW'(CAPACITY));
	assign cmd_pop   = (state_q == S_IDLE) && cmd_valid;

	assign result_valid = res_vld_q;
	assign result       = res_q;

	// Drive the single read and single write port of the store
	always_comb begin
		rd_addr = '0;
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = cmd.value;
		unique case (state_q)
			S_IDLE: begin
				if (cmd_valid && cmd.op == mpq_pkg::OP_INSERT && !is_full) begin
					wr_en   = 1'b1;
					wr_addr = count_q[AW-1:0];
				end
			end
			S_SCAN: begin
				if (issue_q < count_q) begin
					rd_addr = issue_q[AW-1:0];
				end
			end
			S_SHIFT_RD: begin
				if (k_inc < count_q) begin
					rd_addr = k_inc[AW-1:0];
				end
			end
			S_SHIFT_WR: begin
				wr_en   = 1'b1;
				wr_addr = k_q[AW-1:0];
				wr_data = rd_data_q;
			end
			default: begin
				rd_addr = '0;
			end
		endcase
	end

	// Store array with registered read
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_q <= mem[rd_addr];
	end

	// Sequence insert, full and empty results, minimum scan and shift-down
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			issue_q    <= '0;
			pend_q     <= 1'b0;
			pend_idx_q <= '0;
			best_q     <= '0;
			min_q      <= '0;
			k_q        <= '0;
			res_q      <= '0;
			res_vld_q  <= 1'b0;
		end else begin
			res_vld_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (cmd_valid) begin
						if (cmd.op == mpq_pkg::OP_INSERT) begin
							res_vld_q           <= 1'b1;
							res_q.removed_value <= '0;
							if (is_full) begin
								res_q.status    <= mpq_pkg::ST_FULL;
								res_q.occupancy <= 3'(count_q);
							end else begin
								count_q         <= count_q + CW'(1);
								res_q.status    <= mpq_pkg::ST_DONE;
								res_q.occupancy <= 3'(count_q + CW'(1));
							end
						end else if (count_q == '0) begin
							res_vld_q           <= 1'b1;
							res_q.status        <= mpq_pkg::ST_EMPTY;
							res_q.removed_value <= '0;
							res_q.occupancy     <= 3'(count_q);
						end else begin
							issue_q <= '0;
							pend_q  <= 1'b0;
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					// issue one read a cycle, compare the previous one
					if (issue_q < count_q) begin
						issue_q    <= issue_q + CW'(1);
						pend_q     <= 1'b1;
						pend_idx_q <= issue_q;
					end else begin
						pend_q <= 1'b0;
					end
					if (pend_q && take) begin
						min_q  <= rd_data_q;
						best_q <= pend_idx_q;
					end
					if (scan_last) begin
						k_q     <= take ? pend_idx_q : best_q;
						state_q <= S_SHIFT_RD;
					end
				end
				S_SHIFT_RD: begin
					if (k_inc < count_q) begin
						state_q <= S_SHIFT_WR;
					end else begin
						count_q             <= count_q - CW'(1);
						res_vld_q           <= 1'b1;
						res_q.status        <= mpq_pkg::ST_DONE;
						res_q.removed_value <= min_q;
						res_q.occupancy     <= 3'(count_q - CW'(1));
						state_q             <= S_IDLE;
					end
				end
				S_SHIFT_WR: begin
					k_q     <= k_inc;
					state_q <= S_SHIFT_RD;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/min_priority_queue_unit.sv
`timescale 1ns / 1ps

// Ascending priority queue of signed 32-bit values held in arrival order.
// Raise start with a request while busy is low: action 0 inserts value,
// action 1 removes and returns the smallest entry (oldest on ties). Every
// request gives exactly one result, shown for one cycle with result_valid
// high; there is no way to hold it off, so sample it on that cycle. The
// front takes requests into a short command queue and lowers busy again
// as soon as there is room, so up to three requests may be handed over
// while a delete is still at work. An insert, full or empty case is
// answered by the back end straight from its idle state. A delete scans
// all n stored entries, one store read a cycle, then shifts each later
// entry down one place and finishes.
module min_priority_queue_unit #(
	parameter int CAPACITY = mpq_pkg::CAPACITY
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  mpq_pkg::req_t request,
	output logic          busy,
	output logic          result_valid,
	output mpq_pkg::rsp_t result
);

	logic          push;
	mpq_pkg::cmd_t push_cmd;
	logic          push_ready;
	logic          pop;
	mpq_pkg::cmd_t pop_cmd;
	logic          pop_valid;

	// Accept and classify requests
	mpq_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.request    (request),
		.busy       (busy),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_ready (push_ready)
	);

	// Decouple front from back
	mpq_fifo u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.push_ready (push_ready),
		.pop        (pop),
		.pop_cmd    (pop_cmd),
		.pop_valid  (pop_valid)
	);

	// Execute commands on the entry store
	mpq_back #(
		.CAPACITY (CAPACITY)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd_valid    (pop_valid),
		.cmd          (pop_cmd),
		.cmd_pop      (pop),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

// File: tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

	localparam int unsigned CYCLE_LIMIT = 200000;
	localparam int unsigned RANDOM_PER_PHASE = 250;
	localparam int unsigned MAX_GAP = 40;

	// Prediction of the queue contents and the result expected for each transfer
	class mpq_scoreboard;
		logic signed [31:0] held_values[$];
		mpq_pkg::rsp_t      pending_results[$];
		int unsigned        errors;

		function int unsigned held_count();
			return held_values.size();
		endfunction

		function int unsigned outstanding();
			return pending_results.size();
		endfunction

		// Apply one accepted request to the predicted store
		function void note_request(mpq_pkg::req_t req);
			mpq_pkg::rsp_t exp_rsp;
			int            best;
			exp_rsp = '0;
			exp_rsp.status = mpq_pkg::ST_DONE;
			if (req.action == mpq_pkg::ACT_INSERT) begin
				if (held_values.size() >= mpq_pkg::CAPACITY)
					exp_rsp.status = mpq_pkg::ST_FULL;
				else
					held_values.push_back(req.value);
			end else if (held_values.size() == 0) begin
				exp_rsp.status = mpq_pkg::ST_EMPTY;
			end else begin
				// oldest entry wins on equal minima
				best = 0;
				for (int k = 1; k < held_values.size(); k++)
					if (held_values[k] < held_values[best])
						best = k;
				exp_rsp.removed_value = held_values[best];
				held_values.delete(best);
			end
			exp_rsp.occupancy = 3'(held_values.size());
			pending_results.push_back(exp_rsp);
		endfunction

		// Compare one result transfer with the oldest expectation
		function void check_result(mpq_pkg::rsp_t got);
			mpq_pkg::rsp_t exp_rsp;
			if (pending_results.size() == 0) begin
				$error("unexpected result: status %0d removed_value %0d occupancy %0d",
					got.status, got.removed_value, got.occupancy);
				errors++;
				return;
			end
			exp_rsp = pending_results.pop_front();
			if (got.status !== exp_rsp.status) begin
				$error("status: expected %0d, got %0d", exp_rsp.status, got.status);
				errors++;
			end
			if (got.removed_value !== exp_rsp.removed_value) begin
				$error("removed_value: expected %0d, got %0d",
					exp_rsp.removed_value, got.removed_value);
				errors++;
			end
			if (got.occupancy !== exp_rsp.occupancy) begin
				$error("occupancy: expected %0d, got %0d", exp_rsp.occupancy, got.occupancy);
				errors++;
			end
		endfunction
	endclass

	logic          clk;
	logic          arst_n;
	logic          start;
	mpq_pkg::req_t request;
	logic          busy;
	logic          result_valid;
	mpq_pkg::rsp_t result;
	int unsigned   cycles;

	mpq_scoreboard sb = new();

	min_priority_queue_unit dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.request      (request),
		.busy         (busy),
		.result_valid (result_valid),
		.result       (result)
	);

	// Clock
	initial clk = 1'b0;
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Check every result transfer
	always @(posedge clk) begin
		if (arst_n && result_valid)
			sb.check_result(result);
	end

	// Hold start for one transfer after a random idle gap
	task automatic send(input logic act, input logic signed [31:0] val,
		input int unsigned idle_pct);
		mpq_pkg::req_t req;
		int unsigned   gap;
		req.action = act;
		req.value = val;
		gap = 0;
		while (gap < MAX_GAP && $urandom_range(99) < idle_pct)
			gap++;
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		start <= 1'b1;
		request <= req;
		do @(posedge clk); while (busy);
		sb.note_request(req);
	endtask

	// Pick a value: wide random, a narrow band for ties, or an extreme
	function automatic logic signed [31:0] pick_value();
		case ($urandom_range(3))
			0: return $urandom;
			1: return $signed($urandom_range(6)) - 3;
			2: begin
				case ($urandom_range(3))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					2: return 32'sh0;
					default: return -32'sd1;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	initial begin
		int unsigned idle_pct [3];
		cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		request = '0;
		idle_pct = '{0, 48, 25};

		repeat (5) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: empty delete, extremes, full insert, tie handling, bit toggles
		send(mpq_pkg::ACT_DELETE, 32'sd0, 0);
		send(mpq_pkg::ACT_INSERT, 32'sh7fff_ffff, 0);
		send(mpq_pkg::ACT_INSERT, 32'sh8000_0000, 0);
		send(mpq_pkg::ACT_INSERT, 32'sd0, 0);
		send(mpq_pkg::ACT_INSERT, -32'sd1, 0);
		send(mpq_pkg::ACT_INSERT, 32'sd5, 0);
		send(mpq_pkg::ACT_DELETE, 32'sh7fff_ffff, 0);
		send(mpq_pkg::ACT_DELETE, 32'sd0, 0);
		send(mpq_pkg::ACT_INSERT, 32'sd7, 0);
		send(mpq_pkg::ACT_INSERT, 32'sd7, 0);
		send(mpq_pkg::ACT_INSERT, 32'sd3, 0);
		send(mpq_pkg::ACT_DELETE, 32'sd0, 0);
		send(mpq_pkg::ACT_DELETE, 32'sd0, 0);
		send(mpq_pkg::ACT_DELETE, 32'sd0, 0);
		send(mpq_pkg::ACT_DELETE, 32'sd0, 0);
		send(mpq_pkg::ACT_DELETE, 32'sd0, 0);
		send(mpq_pkg::ACT_INSERT, 32'shaaaa_aaaa, 0);
		send(mpq_pkg::ACT_INSERT, 32'sh5555_5555, 0);
		send(mpq_pkg::ACT_DELETE, -32'sd1, 0);
		send(mpq_pkg::ACT_DELETE, 32'sd0, 0);

		// Random: no idling, then heavy and light sender gaps
		foreach (idle_pct[p]) begin
			for (int unsigned n = 0; n < RANDOM_PER_PHASE; n++) begin
				send($urandom_range(1) ? mpq_pkg::ACT_DELETE : mpq_pkg::ACT_INSERT,
					pick_value(), idle_pct[p]);
			end
		end

		@(negedge clk);
		start <= 1'b0;

		// Drain outstanding results, then allow for trailing activity
		while (sb.outstanding() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);

		if (sb.errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
